@@ design/sao_eo45_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SAO edge-offset 45-degree statistics package
// Shared constants, types and small helper functions of the statistics unit.
// ----------------------------------------------------------------------------
package sao_eo45_pkg;

  // Row geometry: one sign slot per column plus the tail slot.
  localparam int ROW_WIDTH   = 64;
  localparam int SLOT_AW     = $clog2(ROW_WIDTH);
  localparam int NUM_CLASSES = 5;
  localparam int CLASS_AW    = $clog2(NUM_CLASSES);
  localparam int ACC_W       = 32;

  // Stream word widths (tdata fields packed from bit 0, padded to whole bytes).
  localparam int S_TDATA_W = 72;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 72;

  localparam logic [CLASS_AW-1:0] MAX_CLASS = CLASS_AW'(NUM_CLASSES - 1);

  typedef enum logic [1:0] {
    REQ_PIXEL      = 2'd0,
    REQ_WRITE_SIGN = 2'd1,
    REQ_READ_CLASS = 2'd2,
    REQ_CLEAR      = 2'd3
  } req_type_e;

  typedef logic signed [1:0] sign_t;

  localparam sign_t SIGN_ZERO = 2'sb00;
  localparam sign_t SIGN_POS  = 2'sb01;
  localparam sign_t SIGN_NEG  = 2'sb11;

  // Count and residual sum of one edge class, as held in the accumulator RAM.
  typedef struct packed {
    logic [ACC_W-1:0] sum;
    logic [ACC_W-1:0] count;
  } acc_t;

  function automatic sign_t sign_of(logic [7:0] a, logic [7:0] b);
    sign_t s;
    if (a > b) begin
      s = SIGN_POS;
    end else if (a < b) begin
      s = SIGN_NEG;
    end else begin
      s = SIGN_ZERO;
    end
    return s;
  endfunction

  // A loaded sign code of 2 (minus two) saturates to minus one.
  function automatic sign_t sat_sign(logic [1:0] v);
    sign_t s;
    case (v)
      2'd0:    s = SIGN_ZERO;
      2'd1:    s = SIGN_POS;
      default: s = SIGN_NEG;
    endcase
    return s;
  endfunction

  // Edge types 0, -2, -1, 1, 2 map to classes 0 to 4.
  function automatic logic [CLASS_AW-1:0] class_of(logic signed [2:0] et);
    logic [CLASS_AW-1:0] c;
    case (et)
      -3'sd2:  c = CLASS_AW'(1);
      -3'sd1:  c = CLASS_AW'(2);
      3'sd1:   c = CLASS_AW'(3);
      3'sd2:   c = CLASS_AW'(4);
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

@@ design/sao_eo45_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sao_eo45_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ design/sao_edge_offset_diag45_stats_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SAO edge-offset statistics unit, 45-degree class
// Classifies pixels by their diagonal edge type and keeps per-class pixel
// counts and residual sums; also loads sign slots, reads and clears classes.
// ----------------------------------------------------------------------------
// Pipeline: an input word passes the sign RAM read at the accepting edge,
//   the accumulator RAM read, then the write-back together with the output
//   register, which holds its result word.
// Throughput: one word per cycle; the whole pipeline only holds while the
//   output register is full and the sink is not ready.
// Reset: asynchronous, active low; clears the sign line, all counts and sums
//   at once through valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module sao_edge_offset_diag45_stats_unit
  import sao_eo45_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Input stream.
  input  wire logic                 s_axis_tvalid_i,
  output      logic                 s_axis_tready_o,
  // tdata from bit 0: column[6], diff_value[16], cur_pixel[8],
  // below_left_pixel[8], right_end_pixel[8], below_end_pixel[8],
  // sign_slot[7], sign_value[2], class_select[3], zero padding[6].
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // tuser from bit 0: req_type[2].
  input  wire logic [S_TUSER_W-1:0] s_axis_tuser_i,
  // Output stream.
  output      logic                 m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // tdata from bit 0: edge_class[3], class_count[32], class_sum[32],
  // zero padding[5].
  output      logic [M_TDATA_W-1:0] m_axis_tdata_o
);

  // --------------------------------------------------------------------------
  // Input word unpacking.
  // --------------------------------------------------------------------------
  req_type_e   in_req;
  logic [5:0]  in_column;
  logic [15:0] in_diff;
  logic [7:0]  in_cur;
  logic [7:0]  in_below_left;
  logic [7:0]  in_right_end;
  logic [7:0]  in_below_end;
  logic [6:0]  in_slot;
  logic [1:0]  in_sign_value;
  logic [2:0]  in_class_sel;

  assign in_req        = req_type_e'(s_axis_tuser_i[1:0]);
  assign in_column     = s_axis_tdata_i[5:0];
  assign in_diff       = s_axis_tdata_i[21:6];
  assign in_cur        = s_axis_tdata_i[29:22];
  assign in_below_left = s_axis_tdata_i[37:30];
  assign in_right_end  = s_axis_tdata_i[45:38];
  assign in_below_end  = s_axis_tdata_i[53:46];
  assign in_slot       = s_axis_tdata_i[60:54];
  assign in_sign_value = s_axis_tdata_i[62:61];
  assign in_class_sel  = s_axis_tdata_i[65:63];

  // The pipeline moves as one: every stage advances whenever the output
  // register is empty or being drained this cycle.
  logic adv;
  logic accept;

  logic out_valid_q;

  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign accept          = s_axis_tvalid_i && adv;

  // --------------------------------------------------------------------------
  // Stage 0: sign line access.
  // Slots 0 to ROW_WIDTH-1 (column k lives in slot k) are held in the sign
  // RAM, the tail slot ROW_WIDTH in a register of its own, so a pixel in the
  // last column can write its down-sign and the tail sign in the same cycle.
  // A pixel reads slot x+1 and writes slot x; the two never collide.
  // --------------------------------------------------------------------------
  logic [SLOT_AW-1:0]   col_x;
  logic                 col_last;
  sign_t                down_sign;
  logic                 slot_is_tail;
  logic                 slot_in_ram;

  logic                 sign_we;
  logic [SLOT_AW-1:0]   sign_waddr;
  sign_t                sign_wdata;
  logic                 sign_re;
  logic [SLOT_AW-1:0]   sign_raddr;
  logic [1:0]           sign_rdata;

  logic [ROW_WIDTH-1:0] sign_vld_q, sign_vld_d;
  sign_t                tail_q, tail_d;

  always_comb begin
    // Columns past the row end are taken as the last column.
    if (32'(in_column) >= 32'(ROW_WIDTH)) begin
      col_x = SLOT_AW'(ROW_WIDTH - 1);
    end else begin
      col_x = SLOT_AW'(in_column);
    end
    col_last     = (col_x == SLOT_AW'(ROW_WIDTH - 1));
    down_sign    = sign_of(in_cur, in_below_left);
    slot_is_tail = (32'(in_slot) == 32'(ROW_WIDTH));
    slot_in_ram  = (32'(in_slot) < 32'(ROW_WIDTH));
  end

  always_comb begin
    sign_we    = 1'b0;
    sign_waddr = col_x;
    sign_wdata = down_sign;
    sign_re    = 1'b0;
    sign_raddr = col_x + SLOT_AW'(1);
    sign_vld_d = sign_vld_q;
    tail_d     = tail_q;
    if (accept) begin
      case (in_req)
        REQ_PIXEL: begin
          sign_we               = 1'b1;
          sign_re               = !col_last;
          sign_vld_d[col_x]     = 1'b1;
          if (col_last) begin
            tail_d = sign_of(in_right_end, in_below_end);
          end
        end
        REQ_WRITE_SIGN: begin
          sign_waddr = SLOT_AW'(in_slot);
          sign_wdata = sat_sign(in_sign_value);
          if (slot_in_ram) begin
            sign_we                         = 1'b1;
            sign_vld_d[SLOT_AW'(in_slot)]   = 1'b1;
          end else if (slot_is_tail) begin
            tail_d = sat_sign(in_sign_value);
          end
        end
        default: begin
        end
      endcase
    end
  end

  sao_eo45_ram #(
    .WIDTH (2),
    .DEPTH (ROW_WIDTH)
  ) u_sign_ram (
    .clk_i   (clk_i),
    .we_i    (sign_we),
    .waddr_i (sign_waddr),
    .wdata_i (sign_wdata),
    .re_i    (sign_re),
    .raddr_i (sign_raddr),
    .rdata_o (sign_rdata)
  );

  // --------------------------------------------------------------------------
  // Stage 1: edge type and class, accumulator RAM read.
  // --------------------------------------------------------------------------
  logic                s1_valid_q;
  req_type_e           s1_req_q;
  sign_t               s1_down_q;
  logic [15:0]         s1_diff_q;
  logic [2:0]          s1_csel_q;
  logic                s1_use_tail_q;
  sign_t               s1_tail_q;
  logic                s1_up_vld_q;

  sign_t               s1_up;
  logic signed [2:0]   s1_edge_type;
  logic [CLASS_AW-1:0] s1_cls;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      sign_vld_q <= '0;
      tail_q     <= SIGN_ZERO;
    end else begin
      sign_vld_q <= sign_vld_d;
      tail_q     <= tail_d;
      if (adv) begin
        s1_valid_q <= s_axis_tvalid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q      <= in_req;
      s1_down_q     <= down_sign;
      s1_diff_q     <= in_diff;
      s1_csel_q     <= in_class_sel;
      s1_use_tail_q <= col_last;
      s1_tail_q     <= tail_q;
      s1_up_vld_q   <= sign_vld_q[sign_raddr];
    end
  end

  always_comb begin
    // A slot never written since reset reads as zero.
    if (s1_use_tail_q) begin
      s1_up = s1_tail_q;
    end else if (s1_up_vld_q) begin
      s1_up = sign_t'(sign_rdata);
    end else begin
      s1_up = SIGN_ZERO;
    end
    s1_edge_type = 3'(s1_down_q) + 3'(s1_up);
    if (s1_req_q == REQ_READ_CLASS) begin
      s1_cls = (s1_csel_q > 3'(MAX_CLASS)) ? MAX_CLASS : CLASS_AW'(s1_csel_q);
    end else begin
      s1_cls = class_of(s1_edge_type);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: accumulate and write back.
  // The entry written in the previous step is forwarded, since the next item
  // read the RAM at that same edge. Classes cleared since their last write
  // read as zero through the per-class valid bits.
  // --------------------------------------------------------------------------
  logic                   s2_valid_q;
  req_type_e              s2_req_q;
  logic [CLASS_AW-1:0]    s2_cls_q;
  logic [15:0]            s2_diff_q;

  logic [NUM_CLASSES-1:0] acc_vld_q, acc_vld_d;
  logic                   wb_valid_q;
  logic [CLASS_AW-1:0]    wb_cls_q;
  acc_t                   wb_data_q;

  acc_t                   acc_rdata;
  acc_t                   acc_old;
  acc_t                   acc_new;
  logic                   acc_we;
  logic                   acc_re;

  assign acc_re = adv && s1_valid_q;

  sao_eo45_ram #(
    .WIDTH ($bits(acc_t)),
    .DEPTH (NUM_CLASSES)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (s2_cls_q),
    .wdata_i (acc_new),
    .re_i    (acc_re),
    .raddr_i (s1_cls),
    .rdata_o (acc_rdata)
  );

  always_comb begin
    if (wb_valid_q && (wb_cls_q == s2_cls_q)) begin
      acc_old = wb_data_q;
    end else if (acc_vld_q[s2_cls_q]) begin
      acc_old = acc_rdata;
    end else begin
      acc_old = '0;
    end
    acc_new.count = acc_old.count + ACC_W'(1);
    acc_new.sum   = acc_old.sum + ACC_W'(signed'(s2_diff_q));
    acc_we        = adv && s2_valid_q && (s2_req_q == REQ_PIXEL);
    acc_vld_d     = acc_vld_q;
    if (adv && s2_valid_q && (s2_req_q == REQ_CLEAR)) begin
      acc_vld_d = '0;
    end else if (acc_we) begin
      acc_vld_d[s2_cls_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      acc_vld_q  <= '0;
      wb_valid_q <= 1'b0;
    end else begin
      acc_vld_q <= acc_vld_d;
      if (adv) begin
        s2_valid_q <= s1_valid_q;
        wb_valid_q <= acc_we;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_req_q  <= s1_req_q;
      s2_cls_q  <= s1_cls;
      s2_diff_q <= s1_diff_q;
      wb_cls_q  <= s2_cls_q;
      wb_data_q <= acc_new;
    end
  end

  // --------------------------------------------------------------------------
  // Output register. Sign writes and clears return an all-zero word.
  // --------------------------------------------------------------------------
  logic [CLASS_AW-1:0] out_cls_q, out_cls_d;
  acc_t                out_acc_q, out_acc_d;

  always_comb begin
    case (s2_req_q)
      REQ_PIXEL: begin
        out_cls_d = s2_cls_q;
        out_acc_d = acc_new;
      end
      REQ_READ_CLASS: begin
        out_cls_d = s2_cls_q;
        out_acc_d = acc_old;
      end
      default: begin
        out_cls_d = '0;
        out_acc_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_cls_q <= out_cls_d;
      out_acc_q <= out_acc_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(M_TDATA_W - 3 - 2 * ACC_W)'(0), out_acc_q.sum,
                            out_acc_q.count, 3'(out_cls_q)};

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // A forwarded write-back always belongs to a class marked as valid.
  a_wb_class_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_valid_q |-> acc_vld_q[wb_cls_q])
    else $error("forwarded class is not marked valid");

  // A clear leaves no class valid and nothing to forward.
  a_clear_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s2_valid_q && (s2_req_q == REQ_CLEAR)) |=>
      (acc_vld_q == '0) && !wb_valid_q)
    else $error("clear left accumulator state behind");

  // The saturated sign code never reaches the tail slot.
  a_tail_sign_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q != 2'sb10)
    else $error("tail slot holds an illegal sign code");

  // While the output stalls, the inner stages hold their items.
  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(s2_valid_q) && $stable(s1_valid_q))
    else $error("pipeline moved during an output stall");

  // Results never carry a class beyond the last one.
  a_class_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_cls_q <= MAX_CLASS))
    else $error("result class out of range");

endmodule
`default_nettype wire
